FILE: rtl/cvmb_pkg.sv
package cvmb_pkg;

	// magnitude width after prescale: largest component lands in [2^29, 2^30)
	localparam int MAG_W = 30;
	// floor(sqrt) of a sum of three squares below 2^62
	localparam int ROOT_W = 31;
	localparam int SUM_W = 62;
	// normalizer pipeline has FRAC_BITS plus this many stages
	localparam int NORM_BASE_LAT = 38;

endpackage

FILE: rtl/cvmb_norm.sv
module cvmb_norm #(
	parameter int IN_W = 32,
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32,
	parameter int SIDE_W = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [2:0][IN_W-1:0] in_v,
	input  logic [SIDE_W-1:0] in_side,
	output logic out_valid,
	output logic [2:0][FRAC_BITS+1:0] out_v,
	output logic [SIDE_W-1:0] out_side
);

	localparam int MW = cvmb_pkg::MAG_W;
	localparam int RW = cvmb_pkg::ROOT_W;
	localparam int SW = cvmb_pkg::SUM_W;
	localparam int OW = FRAC_BITS + 2;
	localparam int QB = FRAC_BITS + 1;
	localparam int NW = MW + QB;
	localparam int NL = FRAC_BITS + cvmb_pkg::NORM_BASE_LAT;
	localparam int LW = $clog2(IN_W);
	localparam int CW = 3 * MW + 4;
	localparam int DRW = RW + 1;
	localparam int TOPB = MW - 1;
	localparam longint LIM = (FRAC_BITS < WORD_BITS - 1) ? (64'sd1 <<< FRAC_BITS) :
		((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);

	// valid and sideband travel alongside the arithmetic
	logic [NL-1:0] vld_q;
	logic [SIDE_W-1:0] side_q [NL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[NL-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= in_side;
		for (int i = 1; i < NL; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	// stage 1: magnitudes and signs
	logic [IN_W-1:0] abs_v [3];
	logic [IN_W-1:0] mag_s1 [3];
	logic [2:0] neg_s1;
	logic [IN_W-1:0] or_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			abs_v[i] = in_v[i][IN_W-1] ? (~in_v[i] + 1'b1) : in_v[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= abs_v[i];
			neg_s1[i] <= in_v[i][IN_W-1];
		end
		or_s1 <= abs_v[0] | abs_v[1] | abs_v[2];
	end

	// stage 2: shift so the leading one sits at bit TOPB
	logic [LW-1:0] lead;
	logic [IN_W+MW-1:0] wide [3];
	logic [MW-1:0] mag_s2 [3];
	logic [2:0] neg_s2;
	logic zero_s2;

	always_comb begin
		lead = '0;
		for (int b = 0; b < IN_W; b++) begin
			if (or_s1[b]) begin
				lead = LW'(b);
			end
		end
		for (int i = 0; i < 3; i++) begin
			wide[i] = {{MW{1'b0}}, mag_s1[i]};
			if (int'(lead) > TOPB) begin
				wide[i] = wide[i] >> (int'(lead) - TOPB);
			end else begin
				wide[i] = wide[i] << (TOPB - int'(lead));
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s2[i] <= wide[i][MW-1:0];
		end
		neg_s2 <= neg_s1;
		zero_s2 <= (or_s1 == '0);
	end

	// stage 3: squares
	logic [2*MW-1:0] sq_s3 [3];
	logic [MW-1:0] mag_s3 [3];
	logic [2:0] neg_s3;
	logic zero_s3;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s3[i] <= mag_s2[i] * mag_s2[i];
			mag_s3[i] <= mag_s2[i];
		end
		neg_s3 <= neg_s2;
		zero_s3 <= zero_s2;
	end

	// stage 4: sum of squares
	logic [SW-1:0] sum_s4;
	logic [CW-1:0] cry_s4;

	always_ff @(posedge clk) begin
		sum_s4 <= SW'(sq_s3[0]) + SW'(sq_s3[1]) + SW'(sq_s3[2]);
		cry_s4 <= {zero_s3, neg_s3, mag_s3[2], mag_s3[1], mag_s3[0]};
	end

	// square root, one result bit per stage
	logic [SW-1:0] rem_sk [RW+1];
	logic [RW-1:0] root_sk [RW+1];
	logic [CW-1:0] cry_sk [RW+1];

	assign rem_sk[0] = sum_s4;
	assign root_sk[0] = '0;
	assign cry_sk[0] = cry_s4;

	for (genvar j = 0; j < RW; j++) begin : g_sqrt
		localparam int K = RW - 1 - j;
		logic [SW:0] trial;
		logic ge;

		always_comb begin
			trial = ((SW+1)'(root_sk[j]) << (K + 1)) | ((SW+1)'(1) << (2 * K));
			ge = ({1'b0, rem_sk[j]} >= trial);
		end

		always_ff @(posedge clk) begin
			rem_sk[j+1] <= ge ? (rem_sk[j] - trial[SW-1:0]) : rem_sk[j];
			root_sk[j+1] <= ge ? (root_sk[j] | (RW'(1) << K)) : root_sk[j];
			cry_sk[j+1] <= cry_sk[j];
		end
	end

	// numerator with half the length added for rounding
	logic [NW-1:0] num_d0 [3];
	logic [RW-1:0] len_d0;
	logic [3:0] zn_d0;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			num_d0[i] <= {1'b0, cry_sk[RW][i*MW +: MW], {FRAC_BITS{1'b0}}} +
				NW'(root_sk[RW] >> 1);
		end
		len_d0 <= root_sk[RW];
		zn_d0 <= cry_sk[RW][CW-1 -: 4];
	end

	// restoring division; the upper quotient bits are known zero
	logic [DRW-1:0] drem_dk [QB+1][3];
	logic [QB-1:0] quo_dk [QB+1][3];
	logic [QB-1:0] low_dk [QB+1][3];
	logic [RW-1:0] len_dk [QB+1];
	logic [3:0] zn_dk [QB+1];

	for (genvar i = 0; i < 3; i++) begin : g_div_in
		assign drem_dk[0][i] = DRW'(num_d0[i][NW-1:QB]);
		assign quo_dk[0][i] = '0;
		assign low_dk[0][i] = num_d0[i][QB-1:0];
	end
	assign len_dk[0] = len_d0;
	assign zn_dk[0] = zn_d0;

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [DRW-1:0] sh [3];
		logic [2:0] ge;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				sh[i] = {drem_dk[j][i][DRW-2:0], low_dk[j][i][QB-1-j]};
				ge[i] = (sh[i] >= DRW'(len_dk[j]));
			end
		end

		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				drem_dk[j+1][i] <= ge[i] ? (sh[i] - DRW'(len_dk[j])) : sh[i];
				quo_dk[j+1][i] <= {quo_dk[j][i][QB-2:0], ge[i]};
				low_dk[j+1][i] <= low_dk[j][i];
			end
			len_dk[j+1] <= len_dk[j];
			zn_dk[j+1] <= zn_dk[j];
		end
	end

	// final: clamp, apply sign, force zero for a zero-length vector
	logic [QB-1:0] qc [3];
	logic [2:0][OW-1:0] out_v_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qc[i] = (64'(quo_dk[QB][i]) > LIM) ? QB'(LIM) : quo_dk[QB][i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (zn_dk[QB][3]) begin
				out_v_q[i] <= '0;
			end else if (zn_dk[QB][i]) begin
				out_v_q[i] <= -OW'(qc[i]);
			end else begin
				out_v_q[i] <= OW'(qc[i]);
			end
		end
	end

	assign out_v = out_v_q;
	assign out_valid = vld_q[NL-1];
	assign out_side = side_q[NL-1];

endmodule

FILE: rtl/camera_view_matrix_builder.sv
// Camera view matrix builder. Accepts one camera word (right, forward and
// position, signed fixed point, Q16.16 at the defaults) in every cycle: busy
// never rises, so start may stay high. Each word yields one result word,
// shown for one cycle with done; the receiver cannot stall. Most of the
// pipeline lies in the two normalizers in series, each a 31-stage square
// root followed by a one-bit-per-stage divider of FRAC_BITS + 1 stages.
// Outputs are the orthonormal right, up and unit forward vectors and the
// negated, saturated dot products of position with them; the last matrix
// column is the constant 0,0,0,1. Zero-length vectors normalize to zero.
module camera_view_matrix_builder #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [WORD_BITS-1:0] right_x,
	input  logic signed [WORD_BITS-1:0] right_y,
	input  logic signed [WORD_BITS-1:0] right_z,
	input  logic signed [WORD_BITS-1:0] fwd_x,
	input  logic signed [WORD_BITS-1:0] fwd_y,
	input  logic signed [WORD_BITS-1:0] fwd_z,
	input  logic signed [WORD_BITS-1:0] pos_x,
	input  logic signed [WORD_BITS-1:0] pos_y,
	input  logic signed [WORD_BITS-1:0] pos_z,
	output logic done,
	output logic signed [WORD_BITS-1:0] view_r_x,
	output logic signed [WORD_BITS-1:0] view_r_y,
	output logic signed [WORD_BITS-1:0] view_r_z,
	output logic signed [WORD_BITS-1:0] view_u_x,
	output logic signed [WORD_BITS-1:0] view_u_y,
	output logic signed [WORD_BITS-1:0] view_u_z,
	output logic signed [WORD_BITS-1:0] view_f_x,
	output logic signed [WORD_BITS-1:0] view_f_y,
	output logic signed [WORD_BITS-1:0] view_f_z,
	output logic signed [WORD_BITS-1:0] view_tx,
	output logic signed [WORD_BITS-1:0] view_ty,
	output logic signed [WORD_BITS-1:0] view_tz
);

	localparam int W = WORD_BITS;
	localparam int MW = cvmb_pkg::MAG_W;
	localparam int RSW = MW + 1;
	localparam int OW = FRAC_BITS + 2;
	localparam int PW = OW + RSW;
	localparam int CW = PW + 1;
	localparam int UW = 2 * OW;
	localparam int DW = UW + 1;
	localparam int EW = W + OW;
	localparam int TW = EW + 2;
	localparam int LW = $clog2(W);
	localparam int TOPB = MW - 1;
	localparam int LAT = 8 + 2 * (FRAC_BITS + cvmb_pkg::NORM_BASE_LAT);
	localparam longint LIM = (FRAC_BITS < WORD_BITS - 1) ? (64'sd1 <<< FRAC_BITS) :
		((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
	localparam logic signed [DW-1:0] LIM_D = DW'(LIM);
	localparam logic signed [W-1:0] LIM_W = W'(LIM);
	localparam logic signed [DW-1:0] HALF_D = DW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [TW-1:0] HALF_T = TW'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [TW-1:0] WMAX_T = TW'($signed({1'b0, {(W-1){1'b1}}}));
	localparam logic signed [TW-1:0] WMIN_T = TW'($signed({1'b1, {(W-1){1'b0}}}));

	// the pipeline never stalls
	assign busy = 1'b0;

	// stage 1: capture the word, take right-vector magnitudes
	logic v_s1;
	logic [W-1:0] rmag_s1 [3];
	logic [2:0] rneg_s1;
	logic [W-1:0] ror_s1;
	logic [2:0][W-1:0] fv_s1;
	logic [2:0][W-1:0] pv_s1;
	logic [W-1:0] rin [3];
	logic [W-1:0] rabs [3];

	assign rin[0] = right_x;
	assign rin[1] = right_y;
	assign rin[2] = right_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rabs[i] = rin[i][W-1] ? (~rin[i] + 1'b1) : rin[i];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rmag_s1[i] <= rabs[i];
			rneg_s1[i] <= rin[i][W-1];
		end
		ror_s1 <= rabs[0] | rabs[1] | rabs[2];
		fv_s1 <= {fwd_z, fwd_y, fwd_x};
		pv_s1 <= {pos_z, pos_y, pos_x};
	end

	// stage 2: prescale right so its largest magnitude lies in [2^29, 2^30)
	logic v_s2;
	logic [LW-1:0] rlead;
	logic [W+MW-1:0] rwide [3];
	logic [2:0][RSW-1:0] rs_s2;
	logic [2:0][W-1:0] fv_s2;
	logic [2:0][W-1:0] pv_s2;

	always_comb begin
		rlead = '0;
		for (int b = 0; b < W; b++) begin
			if (ror_s1[b]) begin
				rlead = LW'(b);
			end
		end
		for (int i = 0; i < 3; i++) begin
			rwide[i] = {{MW{1'b0}}, rmag_s1[i]};
			if (int'(rlead) > TOPB) begin
				rwide[i] = rwide[i] >> (int'(rlead) - TOPB);
			end else begin
				rwide[i] = rwide[i] << (TOPB - int'(rlead));
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (ror_s1 == '0) begin
				rs_s2[i] <= '0;
			end else if (rneg_s1[i]) begin
				rs_s2[i] <= -RSW'(rwide[i][MW-1:0]);
			end else begin
				rs_s2[i] <= RSW'(rwide[i][MW-1:0]);
			end
		end
		fv_s2 <= fv_s1;
		pv_s2 <= pv_s1;
	end

	// normalize forward; carry the prescaled right and the position along
	logic vf_n;
	logic [2:0][OW-1:0] f_n;
	logic [2:0][RSW-1:0] rs_n;
	logic [2:0][W-1:0] pv_n;

	cvmb_norm #(
		.IN_W(W),
		.FRAC_BITS(FRAC_BITS),
		.WORD_BITS(WORD_BITS),
		.SIDE_W(3 * RSW + 3 * W)
	) u_norm_f (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s2),
		.in_v(fv_s2),
		.in_side({rs_s2, pv_s2}),
		.out_valid(vf_n),
		.out_v(f_n),
		.out_side({rs_n, pv_n})
	);

	// stage 3: partial products of f x r
	logic v_s3;
	logic signed [PW-1:0] m_s3 [6];
	logic [2:0][OW-1:0] f_s3;
	logic [2:0][W-1:0] pv_s3;

	always_ff @(posedge clk) begin
		m_s3[0] <= $signed(f_n[1]) * $signed(rs_n[2]);
		m_s3[1] <= $signed(f_n[2]) * $signed(rs_n[1]);
		m_s3[2] <= $signed(f_n[2]) * $signed(rs_n[0]);
		m_s3[3] <= $signed(f_n[0]) * $signed(rs_n[2]);
		m_s3[4] <= $signed(f_n[0]) * $signed(rs_n[1]);
		m_s3[5] <= $signed(f_n[1]) * $signed(rs_n[0]);
		f_s3 <= f_n;
		pv_s3 <= pv_n;
	end

	// stage 4: cross product differences
	logic v_s4;
	logic [2:0][CW-1:0] c_s4;
	logic [2:0][OW-1:0] f_s4;
	logic [2:0][W-1:0] pv_s4;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			c_s4[i] <= CW'(m_s3[2*i]) - CW'(m_s3[2*i+1]);
		end
		f_s4 <= f_s3;
		pv_s4 <= pv_s3;
	end

	// normalize the cross product into up
	logic vu_n;
	logic [2:0][OW-1:0] u_n;
	logic [2:0][OW-1:0] fc_n;
	logic [2:0][W-1:0] pc_n;

	cvmb_norm #(
		.IN_W(CW),
		.FRAC_BITS(FRAC_BITS),
		.WORD_BITS(WORD_BITS),
		.SIDE_W(3 * OW + 3 * W)
	) u_norm_c (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s4),
		.in_v(c_s4),
		.in_side({f_s4, pv_s4}),
		.out_valid(vu_n),
		.out_v(u_n),
		.out_side({fc_n, pc_n})
	);

	// stage 5: partial products of u x f
	logic v_s5;
	logic signed [UW-1:0] a_s5 [3];
	logic signed [UW-1:0] b_s5 [3];
	logic [2:0][OW-1:0] u_s5;
	logic [2:0][OW-1:0] f_s5;
	logic [2:0][W-1:0] pv_s5;

	always_ff @(posedge clk) begin
		a_s5[0] <= $signed(u_n[1]) * $signed(fc_n[2]);
		b_s5[0] <= $signed(u_n[2]) * $signed(fc_n[1]);
		a_s5[1] <= $signed(u_n[2]) * $signed(fc_n[0]);
		b_s5[1] <= $signed(u_n[0]) * $signed(fc_n[2]);
		a_s5[2] <= $signed(u_n[0]) * $signed(fc_n[1]);
		b_s5[2] <= $signed(u_n[1]) * $signed(fc_n[0]);
		u_s5 <= u_n;
		f_s5 <= fc_n;
		pv_s5 <= pc_n;
	end

	// stage 6: round the recomputed right and clamp it
	logic v_s6;
	logic signed [DW-1:0] rt [3];
	logic signed [DW-1:0] rc [3];
	logic [2:0][OW-1:0] r_s6;
	logic [2:0][OW-1:0] u_s6;
	logic [2:0][OW-1:0] f_s6;
	logic [2:0][W-1:0] pv_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rt[i] = (DW'(a_s5[i]) - DW'(b_s5[i]) + HALF_D) >>> FRAC_BITS;
			if (rt[i] > LIM_D) begin
				rc[i] = LIM_D;
			end else if (rt[i] < -LIM_D) begin
				rc[i] = -LIM_D;
			end else begin
				rc[i] = rt[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			r_s6[i] <= rc[i][OW-1:0];
		end
		u_s6 <= u_s5;
		f_s6 <= f_s5;
		pv_s6 <= pv_s5;
	end

	// stage 7: position times each basis entry
	logic v_s7;
	logic signed [EW-1:0] dp_s7 [3][3];
	logic [2:0][OW-1:0] r_s7;
	logic [2:0][OW-1:0] u_s7;
	logic [2:0][OW-1:0] f_s7;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dp_s7[0][i] <= $signed(pv_s6[i]) * $signed(r_s6[i]);
			dp_s7[1][i] <= $signed(pv_s6[i]) * $signed(u_s6[i]);
			dp_s7[2][i] <= $signed(pv_s6[i]) * $signed(f_s6[i]);
		end
		r_s7 <= r_s6;
		u_s7 <= u_s6;
		f_s7 <= f_s6;
	end

	// stage 8: sum, round half up, negate, saturate; drive the result word
	logic v_s8;
	logic signed [TW-1:0] dsum [3];
	logic signed [TW-1:0] dneg [3];
	logic signed [W-1:0] dsat [3];

	always_comb begin
		for (int b = 0; b < 3; b++) begin
			dsum[b] = (TW'(dp_s7[b][0]) + TW'(dp_s7[b][1]) + TW'(dp_s7[b][2]) + HALF_T)
				>>> FRAC_BITS;
			dneg[b] = -dsum[b];
			if (dneg[b] > WMAX_T) begin
				dsat[b] = WMAX_T[W-1:0];
			end else if (dneg[b] < WMIN_T) begin
				dsat[b] = WMIN_T[W-1:0];
			end else begin
				dsat[b] = dneg[b][W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		view_r_x <= W'($signed(r_s7[0]));
		view_r_y <= W'($signed(r_s7[1]));
		view_r_z <= W'($signed(r_s7[2]));
		view_u_x <= W'($signed(u_s7[0]));
		view_u_y <= W'($signed(u_s7[1]));
		view_u_z <= W'($signed(u_s7[2]));
		view_f_x <= W'($signed(f_s7[0]));
		view_f_y <= W'($signed(f_s7[1]));
		view_f_z <= W'($signed(f_s7[2]));
		view_tx <= dsat[0];
		view_ty <= dsat[1];
		view_tz <= dsat[2];
	end

	// valid bits; clear on reset, advance every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= vf_n;
			v_s4 <= v_s3;
			v_s5 <= vu_n;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	assign done = v_s8;

	// every accepted word comes out on done
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("accepted word did not complete on time");

	// no result without a matching accepted word
	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result without a matching word");

	// unit forward stays inside the basis clamp
	a_fwd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (view_f_x <= LIM_W && view_f_x >= -LIM_W &&
			view_f_y <= LIM_W && view_f_y >= -LIM_W &&
			view_f_z <= LIM_W && view_f_z >= -LIM_W))
		else $error("forward entry beyond the clamp");

	// zero forward forces zero up and right
	a_zero_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(done && view_f_x == '0 && view_f_y == '0 && view_f_z == '0) |->
		(view_u_x == '0 && view_u_y == '0 && view_u_z == '0 &&
			view_r_x == '0 && view_r_y == '0 && view_r_z == '0))
		else $error("zero forward gave a nonzero basis");

endmodule

FILE: verif/view_matrix_checker.sv
module view_matrix_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic signed [31:0] right_x,
	input  logic signed [31:0] right_y,
	input  logic signed [31:0] right_z,
	input  logic signed [31:0] fwd_x,
	input  logic signed [31:0] fwd_y,
	input  logic signed [31:0] fwd_z,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic done,
	input  logic signed [31:0] view_r_x,
	input  logic signed [31:0] view_r_y,
	input  logic signed [31:0] view_r_z,
	input  logic signed [31:0] view_u_x,
	input  logic signed [31:0] view_u_y,
	input  logic signed [31:0] view_u_z,
	input  logic signed [31:0] view_f_x,
	input  logic signed [31:0] view_f_y,
	input  logic signed [31:0] view_f_z,
	input  logic signed [31:0] view_tx,
	input  logic signed [31:0] view_ty,
	input  logic signed [31:0] view_tz,
	output int errors,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef longint vec3_t [3];
	typedef longint unsigned uvec3_t [3];
	typedef logic [11:0][31:0] view_t;

	localparam longint ONE = 64'sd65536;
	localparam longint HALF = 64'sd32768;
	localparam longint WMAX = 64'sd2147483647;

	view_t expected_views [$];

	function automatic longint clamp_unit(input longint v);
		if (v > ONE)
			return ONE;
		if (v < -ONE)
			return -ONE;
		return v;
	endfunction

	function automatic longint unsigned root64(input longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// scale so the largest magnitude sits in [2^29, 2^30)
	function automatic bit fit_range(input vec3_t v, output uvec3_t mag, output bit [2:0] neg);
		longint unsigned mx;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = v[i] < 0;
			mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
			if (mag[i] > mx)
				mx = mag[i];
		end
		if (mx == 0)
			return 0;
		while (mx >= (64'd1 << 30)) begin
			mx >>= 1;
			for (int i = 0; i < 3; i++)
				mag[i] >>= 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx <<= 1;
			for (int i = 0; i < 3; i++)
				mag[i] <<= 1;
		end
		return 1;
	endfunction

	function automatic void unit_vec(input vec3_t v, output vec3_t o);
		uvec3_t mag;
		bit [2:0] neg;
		longint unsigned len, q;
		o = '{0, 0, 0};
		if (!fit_range(v, mag, neg))
			return;
		len = root64(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << 16) + (len >> 1)) / len;
			o[i] = clamp_unit(neg[i] ? -longint'(q) : longint'(q));
		end
	endfunction

	// -(p . b), rounded half up, saturated to the word range
	function automatic longint neg_dot_sat(input vec3_t p, input vec3_t b);
		longint acc;
		acc = p[0] * b[0] + p[1] * b[1] + p[2] * b[2];
		acc = -((acc + HALF) >>> 16);
		if (acc > WMAX)
			return WMAX;
		if (acc < -WMAX - 1)
			return -WMAX - 1;
		return acc;
	endfunction

	function automatic view_t predict_view(input vec3_t rv, input vec3_t fv, input vec3_t pv);
		vec3_t f, u, r, c, rs;
		uvec3_t mag;
		bit [2:0] neg;
		view_t res;
		longint t;
		unit_vec(fv, f);
		rs = '{0, 0, 0};
		if (fit_range(rv, mag, neg))
			for (int i = 0; i < 3; i++)
				rs[i] = neg[i] ? -longint'(mag[i]) : longint'(mag[i]);
		c[0] = f[1] * rs[2] - f[2] * rs[1];
		c[1] = f[2] * rs[0] - f[0] * rs[2];
		c[2] = f[0] * rs[1] - f[1] * rs[0];
		unit_vec(c, u);
		r[0] = clamp_unit((u[1] * f[2] - u[2] * f[1] + HALF) >>> 16);
		r[1] = clamp_unit((u[2] * f[0] - u[0] * f[2] + HALF) >>> 16);
		r[2] = clamp_unit((u[0] * f[1] - u[1] * f[0] + HALF) >>> 16);
		for (int i = 0; i < 3; i++) begin
			res[i] = r[i][31:0];
			res[3 + i] = u[i][31:0];
			res[6 + i] = f[i][31:0];
		end
		t = neg_dot_sat(pv, r);
		res[9] = t[31:0];
		t = neg_dot_sat(pv, u);
		res[10] = t[31:0];
		t = neg_dot_sat(pv, f);
		res[11] = t[31:0];
		return res;
	endfunction

	string field_names [12] = '{"view_r_x", "view_r_y", "view_r_z", "view_u_x", "view_u_y",
		"view_u_z", "view_f_x", "view_f_y", "view_f_z", "view_tx", "view_ty", "view_tz"};

	always @(posedge clk or negedge arst_n) begin
		view_t got, exp_v;
		int miss;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
		end else begin
			miss = 0;
			if (start && !busy)
				expected_views.push_back(predict_view(
					'{right_x, right_y, right_z}, '{fwd_x, fwd_y, fwd_z},
					'{pos_x, pos_y, pos_z}));
			if (done) begin
				got = {view_tz, view_ty, view_tx, view_f_z, view_f_y, view_f_x,
					view_u_z, view_u_y, view_u_x, view_r_z, view_r_y, view_r_x};
				if (expected_views.size() == 0) begin
					$display("%t: result word with nothing expected", $time);
					miss = 1;
				end else begin
					exp_v = expected_views.pop_front();
					for (int i = 0; i < 12; i++)
						if (got[i] !== exp_v[i]) begin
							$display("%t: %s expected %h actual %h", $time, field_names[i],
								exp_v[i], got[i]);
							miss++;
						end
				end
			end
			errors <= errors + miss;
			pending <= expected_views.size();
		end
	end

endmodule

FILE: verif/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 400000;
	localparam int LAT = 116;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [31:0] right_x, right_y, right_z;
	logic signed [31:0] fwd_x, fwd_y, fwd_z;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic done;
	logic signed [31:0] view_r_x, view_r_y, view_r_z;
	logic signed [31:0] view_u_x, view_u_y, view_u_z;
	logic signed [31:0] view_f_x, view_f_y, view_f_z;
	logic signed [31:0] view_tx, view_ty, view_tz;
	int errors;
	int pending;
	int cycles;
	int words_sent;

	camera_view_matrix_builder u_top (.*);
	view_matrix_checker u_chk (.*);

	// free-running clock, 2 ns period
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// watchdog: end the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// one component: full range, shifted, small, extreme, single-bit or zero
	function automatic logic [31:0] pick_comp();
		case ($urandom_range(0, 6))
			0, 1: return $urandom;
			2: return 32'($urandom_range(0, 262143)) - 32'd131072;
			3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			4: return 32'($urandom_range(0, 7)) - 32'd3;
			5: return $urandom >>> $urandom_range(0, 31);
			default: return 32'($urandom_range(0, 1)) << $urandom_range(0, 31);
		endcase
	endfunction

	// drive one camera word and hold it until the block takes it
	task automatic send_word(input logic [31:0] rx, ry, rz, fx, fy, fz, px, py, pz,
		input int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		right_x <= rx; right_y <= ry; right_z <= rz;
		fwd_x <= fx; fwd_y <= fy; fwd_z <= fz;
		pos_x <= px; pos_y <= py; pos_z <= pz;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		words_sent++;
	endtask

	// random camera: mostly sane bases, some parallel or degenerate ones
	task automatic send_random(input int idle_pct);
		logic [31:0] f [3];
		logic [31:0] r [3];
		int sh;
		for (int i = 0; i < 3; i++) begin
			f[i] = pick_comp();
			r[i] = pick_comp();
		end
		case ($urandom_range(0, 9))
			0: begin
				// right parallel to forward
				sh = $urandom_range(0, 4);
				for (int i = 0; i < 3; i++)
					r[i] = $signed(f[i]) >>> sh;
			end
			1: f = '{0, 0, 0};
			2: r = '{0, 0, 0};
			default: ;
		endcase
		send_word(r[0], r[1], r[2], f[0], f[1], f[2], pick_comp(), pick_comp(), pick_comp(),
			idle_pct);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		start = 1'b0;
		{right_x, right_y, right_z, fwd_x, fwd_y, fwd_z, pos_x, pos_y, pos_z} = '0;
		cycles = 0;
		words_sent = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: axis-aligned camera, then extremes and degenerate bases
		send_word(32'h10000, 0, 0, 0, 0, 32'h10000, 32'h30000, 32'hfffe0000, 32'h5000, 0);
		send_word(0, 0, 0, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
		send_word(32'h10000, 32'h20000, 0, 0, 0, 0, 1, 2, 3, 0);
		send_word(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h100, 0, 0, 0);
		send_word(32'h20000, 32'h20000, 32'h20000, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 0);
		send_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
		send_word(32'h80000000, 0, 0, 0, 32'h7fffffff, 0, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 0);
		send_word(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 0);
		send_word(1, 0, 0, 0, 0, 1, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0);
		send_word(0, 1, 0, 32'hffffffff, 0, 0, 32'h8000, 32'h8000, 32'h8000, 0);
		send_word(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h1, 32'h0, 32'hffffffff,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
		send_word(32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 32'hf0f0f0f0, 32'h33333333,
			32'hcccccccc, 32'haaaaaaaa, 32'h55555555, 32'hffff0000, 0);
		send_word(32'h40000000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h40000000, 32'h7fff8000,
			32'h0, 32'h80008000, 0);
		send_word(32'h10000, 0, 0, 32'h10000, 32'h1, 0, 32'h12345678, 32'h9abcdef0,
			32'h0fedcba9, 0);

		// hold off until every result is back
		drain();

		// random: the sender idles with a 28 percent chance each time, then 58, then never
		for (int n = 0; n < 550; n++)
			send_random(28);
		for (int n = 0; n < 550; n++)
			send_random(58);
		drain();
		for (int n = 0; n < 550; n++)
			send_random(0);

		drain();
		repeat (LAT + 20) @(posedge clk);
		$display("Sent %0d camera words: axis, extreme, zero-length and parallel bases,", words_sent);
		$display("random Q16.16 fields with idle gaps and back-to-back streams.");
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
